### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the RTL. They are empty when SYNTH
// is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// The property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

### sv/pma_pkg.sv
// ----------------------------------------------------------------------------
// Moving average package
// Shared constants and types of the primed moving average filter.
// ----------------------------------------------------------------------------
package pma_pkg;

	// Width of the window length register.
	localparam int LEN_BITS = 6;
	// Window length after reset, limited to the largest window.
	localparam int WINDOW_RESET = 32;
	localparam int DEF_MAX_WINDOW = 32;
	localparam int DEF_SAMPLE_BITS = 16;

	// What the front decided a sample is for.
	typedef enum logic {
		KIND_PRIME,
		KIND_UPDATE
	} item_kind_t;

	// Control side of the queue output.
	typedef struct packed {
		logic       valid;
		item_kind_t kind;
	} q_ctl_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_FILL,
		B_READ,
		B_SUM,
		B_ABS,
		B_DIV,
		B_SIGN,
		B_OUT
	} back_state_t;

endpackage

### sv/pma_front.sv
// ----------------------------------------------------------------------------
// Moving average front end
// Accepts sample requests and tags each as a priming or an update item.
// ----------------------------------------------------------------------------
module pma_front
	import pma_pkg::*;
#(
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
	parameter int DATA_BITS   = ((DEF_SAMPLE_BITS + 7) / 8) * 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [DATA_BITS-1:0]   s_tdata,
	input  logic                   cfg_clear,
	input  logic                   q_full,
	output logic                   push,
	output item_kind_t             push_kind,
	output logic [SAMPLE_BITS-1:0] push_sample
);

	logic primed_q;

	assign s_tready    = !q_full;
	assign push        = s_tvalid && !q_full;
	assign push_kind   = primed_q ? KIND_UPDATE : KIND_PRIME;
	assign push_sample = s_tdata[SAMPLE_BITS-1:0];

	// The first sample after reset or a new window length primes the filter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			primed_q <= 1'b0;
		end else if (cfg_clear) begin
			primed_q <= 1'b0;
		end else if (push) begin
			primed_q <= 1'b1;
		end
	end

endmodule

### sv/pma_queue.sv
// ----------------------------------------------------------------------------
// Moving average item queue
// Two-entry queue between the front end and the back end.
// ----------------------------------------------------------------------------
module pma_queue
	import pma_pkg::*;
#(
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  item_kind_t             push_kind,
	input  logic [SAMPLE_BITS-1:0] push_sample,
	output logic                   full,
	input  logic                   pop,
	output q_ctl_t                 head,
	output logic [SAMPLE_BITS-1:0] head_sample
);

	logic [1:0]             count_q;
	logic                   wr_ptr_q;
	logic                   rd_ptr_q;
	item_kind_t             kind_q   [2];
	logic [SAMPLE_BITS-1:0] sample_q [2];

	assign full             = (count_q == 2'd2);
	assign head.valid       = (count_q != 2'd0);
	assign head.kind        = kind_q[rd_ptr_q];
	assign head_sample      = sample_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= 2'd0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			kind_q[wr_ptr_q]   <= push_kind;
			sample_q[wr_ptr_q] <= push_sample;
		end
	end

endmodule

### sv/pma_back.sv
// ----------------------------------------------------------------------------
// Moving average back end
// Window store, running sum, iterative divider and output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pma_back
	import pma_pkg::*;
#(
	parameter int MAX_WINDOW  = DEF_MAX_WINDOW,
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
	parameter int DATA_BITS   = ((DEF_SAMPLE_BITS + 7) / 8) * 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [LEN_BITS-1:0]    window_len,
	input  q_ctl_t                 head,
	input  logic [SAMPLE_BITS-1:0] head_sample,
	output logic                   pop,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [DATA_BITS-1:0]   m_tdata
);

	localparam int LEN_MAX = (MAX_WINDOW < (1 << LEN_BITS)) ? MAX_WINDOW
		: (1 << LEN_BITS) - 1;
	localparam int PW      = $clog2(MAX_WINDOW);
	localparam int SW      = SAMPLE_BITS + $clog2(LEN_MAX);
	localparam int CW      = (PW + 1 > LEN_BITS) ? PW + 1 : LEN_BITS;
	localparam int RB      = LEN_BITS + 1;
	localparam int NW      = $clog2(SW);

	back_state_t            state_q, state_d;
	logic [SAMPLE_BITS-1:0] mem [MAX_WINDOW];
	logic [SAMPLE_BITS-1:0] rd_q;
	logic [SAMPLE_BITS-1:0] sample_q;
	logic [SAMPLE_BITS-1:0] res_q;
	logic [SAMPLE_BITS-1:0] m_data_q;
	logic                   m_valid_q;
	logic [PW-1:0]          ptr_q;
	logic [PW-1:0]          idx_q;
	logic [SW-1:0]          sum_q;
	logic [SW-1:0]          dq_q;
	logic [RB-1:0]          rem_q;
	logic [NW-1:0]          cnt_q;
	logic                   neg_q;

	logic                   mem_we;
	logic [PW-1:0]          mem_waddr;
	logic [CW-1:0]          len_ext;
	logic [CW-1:0]          ptr_inc;
	logic [CW-1:0]          idx_inc;
	logic                   ptr_wrap;
	logic                   idx_last;
	logic [SW-1:0]          sample_sx;
	logic [SW-1:0]          rd_sx;
	logic [RB-1:0]          rem_sh;
	logic                   rem_ge;
	logic                   out_free;

	assign len_ext   = CW'(window_len);
	assign ptr_inc   = CW'(ptr_q) + CW'(1);
	assign idx_inc   = CW'(idx_q) + CW'(1);
	assign ptr_wrap  = (ptr_inc == len_ext);
	assign idx_last  = (idx_inc == len_ext);
	assign sample_sx = {{(SW-SAMPLE_BITS){sample_q[SAMPLE_BITS-1]}}, sample_q};
	assign rd_sx     = {{(SW-SAMPLE_BITS){rd_q[SAMPLE_BITS-1]}}, rd_q};
	assign rem_sh    = {rem_q[RB-2:0], dq_q[SW-1]};
	assign rem_ge    = (rem_sh >= RB'(window_len));
	assign out_free  = !m_valid_q || m_tready;
	assign mem_we    = (state_q == B_FILL) || (state_q == B_SUM);
	assign mem_waddr = (state_q == B_FILL) ? idx_q : ptr_q;

	assign m_tvalid  = m_valid_q;
	assign m_tdata   = DATA_BITS'(m_data_q);

	// Window store: one write port, registered read at the write pointer.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= sample_q;
		end
		rd_q <= mem[ptr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		pop     = 1'b0;
		unique case (state_q)
			B_IDLE: begin
				if (head.valid) begin
					pop     = 1'b1;
					state_d = (head.kind == KIND_PRIME) ? B_FILL : B_READ;
				end
			end
			B_FILL: begin
				if (idx_last) begin
					state_d = B_OUT;
				end
			end
			B_READ: state_d = B_SUM;
			B_SUM:  state_d = B_ABS;
			B_ABS:  state_d = B_DIV;
			B_DIV: begin
				if (cnt_q == NW'(SW - 1)) begin
					state_d = B_SIGN;
				end
			end
			B_SIGN: state_d = B_OUT;
			B_OUT: begin
				if (out_free) begin
					state_d = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q     <= '0;
			sum_q     <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (state_q == B_FILL) begin
				sum_q <= sum_q + sample_sx;
				ptr_q <= '0;
			end else if (state_q == B_IDLE && pop && head.kind == KIND_PRIME) begin
				sum_q <= '0;
			end else if (state_q == B_SUM) begin
				sum_q <= sum_q - rd_sx + sample_sx;
				ptr_q <= ptr_wrap ? '0 : ptr_inc[PW-1:0];
			end
			if (state_q == B_OUT && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			B_IDLE: begin
				sample_q <= head_sample;
				idx_q    <= '0;
			end
			B_FILL: begin
				idx_q <= idx_inc[PW-1:0];
				res_q <= sample_q;
			end
			B_ABS: begin
				neg_q <= sum_q[SW-1];
				dq_q  <= sum_q[SW-1] ? -sum_q : sum_q;
				rem_q <= '0;
				cnt_q <= '0;
			end
			B_DIV: begin
				// Restoring division, one quotient bit a cycle.
				rem_q <= rem_ge ? rem_sh - RB'(window_len) : rem_sh;
				dq_q  <= {dq_q[SW-2:0], rem_ge};
				cnt_q <= cnt_q + NW'(1);
			end
			B_SIGN: begin
				res_q <= neg_q ? -dq_q[SAMPLE_BITS-1:0] : dq_q[SAMPLE_BITS-1:0];
			end
			B_OUT: begin
				if (out_free) begin
					m_data_q <= res_q;
				end
			end
			default: begin
			end
		endcase
	end

	`ASSERT_ALWAYS(a_ptr_in_window, clk, arst_n,
		state_q != B_SUM || CW'(ptr_q) < len_ext, "write pointer outside the window")
	`ASSERT_ALWAYS(a_fill_in_window, clk, arst_n,
		state_q != B_FILL || CW'(idx_q) < len_ext, "fill index outside the window")
	`ASSERT_NEXT(a_out_loaded, clk, arst_n, state_q == B_OUT && out_free,
		m_valid_q && state_q == B_IDLE, "result not presented after loading")
	`ASSERT_NEXT(a_pop_only_idle, clk, arst_n, pop,
		state_q == B_FILL || state_q == B_READ, "item taken outside idle")

endmodule

### sv/primed_moving_average.sv
// ----------------------------------------------------------------------------
// Primed moving average
// Boxcar moving average of signed fixed-point samples over a programmable
// window, primed by the first sample after reset or a window change.
// ----------------------------------------------------------------------------
// Samples arrive as requests on the s_ channel and averages leave on the m_
// channel, one average for every sample, in order. The window length is set
// through cfg_we/cfg_wdata; a value of zero or above the largest window is
// ignored, and a valid write restarts the filter so that the next sample
// primes it. Write it only while no sample is in flight.
// A priming sample fills every window slot, one slot per cycle from the
// single write port of the window store, and is returned unchanged.
// A later sample reads the oldest slot, updates the running sum and then
// goes through a restoring divider that produces one quotient bit per
// cycle. The back end works on one sample at a time; a two-entry queue
// keeps accepting samples meanwhile. A result waits in an output register;
// while the receiver stalls with that register full, the back end holds
// its next result, and once the queue has filled as well the input stops
// accepting. Reset clears the filter, sets the window length to 32 (or to
// the largest window if that is smaller) and empties the queue and the
// output register. The window store is not cleared: priming writes every
// slot before a read.
// ----------------------------------------------------------------------------
module primed_moving_average
	import pma_pkg::*;
#(
	parameter int MAX_WINDOW  = DEF_MAX_WINDOW,
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
	parameter int DATA_BITS   = ((SAMPLE_BITS + 7) / 8) * 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// Sample requests.
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [DATA_BITS-1:0] s_tdata,   // sample, zero padding above
	// Average results.
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [DATA_BITS-1:0] m_tdata,   // average, zero padding above
	// Window length register.
	input  logic                 cfg_we,
	input  logic [LEN_BITS-1:0]  cfg_wdata  // window_length
);

	localparam int LEN_MAX   = (MAX_WINDOW < (1 << LEN_BITS)) ? MAX_WINDOW
		: (1 << LEN_BITS) - 1;
	localparam int LEN_RESET = (WINDOW_RESET > LEN_MAX) ? LEN_MAX : WINDOW_RESET;

	logic [LEN_BITS-1:0]    window_len_q;
	logic                   cfg_ok;
	logic                   q_full;
	logic                   push;
	item_kind_t             push_kind;
	logic [SAMPLE_BITS-1:0] push_sample;
	logic                   pop;
	q_ctl_t                 head;
	logic [SAMPLE_BITS-1:0] head_sample;

	// Out-of-range window lengths leave the register and the filter untouched.
	assign cfg_ok = cfg_we && (cfg_wdata != '0) && (int'(cfg_wdata) <= LEN_MAX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_len_q <= LEN_BITS'(LEN_RESET);
		end else if (cfg_ok) begin
			window_len_q <= cfg_wdata;
		end
	end

	// The front end tags each sample; a valid write also clears its primed flag.
	pma_front #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.DATA_BITS   (DATA_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.cfg_clear   (cfg_ok),
		.q_full      (q_full),
		.push        (push),
		.push_kind   (push_kind),
		.push_sample (push_sample)
	);

	pma_queue #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_queue (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.push_kind   (push_kind),
		.push_sample (push_sample),
		.full        (q_full),
		.pop         (pop),
		.head        (head),
		.head_sample (head_sample)
	);

	// The back end owns the window store, the running sum and the divider.
	pma_back #(
		.MAX_WINDOW  (MAX_WINDOW),
		.SAMPLE_BITS (SAMPLE_BITS),
		.DATA_BITS   (DATA_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.window_len  (window_len_q),
		.head        (head),
		.head_sample (head_sample),
		.pop         (pop),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata)
	);

endmodule

### test/primed_moving_average_tb.sv
// ----------------------------------------------------------------------------
// Primed moving average testbench
// Sends sample requests through the stream input and checks every average
// against a behavioural copy of the filter kept in this file. Directed tests
// cover the reset window, a window of one, ignored window writes, the largest
// window and rounding toward zero. Random bursts follow over changing windows,
// with the sender and the receiver idling at different rates.
// ----------------------------------------------------------------------------
module primed_moving_average_tb;
	import pma_pkg::*;

	localparam int WIN_MAX  = DEF_MAX_WINDOW;
	localparam int SMP_BITS = DEF_SAMPLE_BITS;
	localparam int DAT_BITS = ((SMP_BITS + 7) / 8) * 8;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                s_tvalid  = 1'b0;
	logic                s_tready;
	logic [DAT_BITS-1:0] s_tdata   = '0;  // sample
	logic                m_tvalid;
	logic                m_tready  = 1'b0;
	logic [DAT_BITS-1:0] m_tdata;         // average
	logic                cfg_we    = 1'b0;
	logic [LEN_BITS-1:0] cfg_wdata = '0;  // window_length

	// Percentages of cycles in which each side holds back.
	int unsigned sender_idle_pct   = 11;
	int unsigned receiver_idle_pct = 85;
	int unsigned mismatch_count    = 0;
	int unsigned samples_sent      = 0;

	// Averages still owed by the filter, oldest first.
	logic [SMP_BITS-1:0] pending_averages[$];

	// Our own copy of the filter state and its window length.
	logic signed [SMP_BITS-1:0] window_slots[WIN_MAX];
	int                         window_sum;
	int                         slot_ptr;
	bit                         is_primed;
	int                         window_len;

	primed_moving_average u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Works out the average that one accepted sample produces and moves the
	// filter state on. The first sample after a restart fills the window.
	function automatic logic [SMP_BITS-1:0] predict_average(input logic signed [SMP_BITS-1:0] smp);
		int avg;
		if (!is_primed) begin
			for (int i = 0; i < window_len; i++)
				window_slots[i] = smp;
			window_sum = window_len * smp;
			slot_ptr   = 0;
			is_primed  = 1'b1;
			return smp;
		end
		window_sum = window_sum - window_slots[slot_ptr] + smp;
		window_slots[slot_ptr] = smp;
		// Integer division in SystemVerilog already truncates toward zero.
		avg = window_sum / window_len;
		slot_ptr = (slot_ptr + 1) % window_len;
		return avg[SMP_BITS-1:0];
	endfunction

	// The receiver decides at every falling edge whether it takes a result.
	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= receiver_idle_pct);
	end

	// Every result that is taken is compared with the oldest owed average.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_averages.size() == 0) begin
				mismatch_count++;
				$display("%0t: average expected none, actual %0d", $time, $signed(m_tdata));
			end else begin
				if (m_tdata !== pending_averages[0]) begin
					mismatch_count++;
					$display("%0t: average expected %0d, actual %0d", $time,
						$signed(pending_averages[0]), $signed(m_tdata));
				end
				void'(pending_averages.pop_front());
			end
		end
	end

	// Presents one sample request after a random number of idle cycles and
	// returns at the rising edge that accepts it. The valid is left high so
	// that a following request can go out without a gap.
	task automatic send_sample(input logic signed [SMP_BITS-1:0] smp);
		@(negedge clk);
		while ($urandom_range(99) < sender_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= DAT_BITS'(smp) & DAT_BITS'({SMP_BITS{1'b1}});
		do
			@(posedge clk);
		while (!s_tready);
		pending_averages.push_back(predict_average(smp));
		samples_sent++;
	endtask

	// Holds the sender back until every owed average has come, then gives
	// the back end time to return to idle.
	task automatic drain_results;
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_averages.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Writes the window length once the filter is idle. A write of zero or
	// above the largest window leaves the length and the filter untouched.
	task automatic write_window(input logic [LEN_BITS-1:0] len);
		drain_results();
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= len;
		@(negedge clk);
		cfg_we    <= 1'b0;
		if (len != 0 && len <= WIN_MAX) begin
			window_len = len;
			window_sum = 0;
			slot_ptr   = 0;
			is_primed  = 1'b0;
		end
	endtask

	// Mostly full-range samples, with the extremes and values near zero
	// mixed in so that rounding and the largest sums are reached often.
	function automatic logic signed [SMP_BITS-1:0] random_sample;
		int unsigned pick;
		pick = $urandom_range(15);
		if (pick < 2)
			return (pick == 0) ? {1'b1, {(SMP_BITS-1){1'b0}}} : {1'b0, {(SMP_BITS-1){1'b1}}};
		else if (pick < 6)
			return SMP_BITS'($signed($urandom_range(8)) - 4);
		return SMP_BITS'($urandom);
	endfunction

	// The reset window of 32: priming with the most negative sample, then the
	// extremes and the values around zero.
	task automatic test_reset_window;
		send_sample(-16'sd32768);
		send_sample(16'sd32767);
		send_sample(-16'sd1);
		send_sample(16'sd0);
		send_sample(16'sd1);
		send_sample(16'sh5555);
	endtask

	// With a window of one every sample comes back unchanged.
	task automatic test_window_of_one;
		write_window(LEN_BITS'(1));
		send_sample(16'sd1234);
		send_sample(-16'sd32768);
		send_sample(16'sd32767);
		send_sample(-16'sh5556);
	endtask

	// Writes of zero and above the largest window are dropped, so the filter
	// stays primed and goes on averaging over the old window.
	task automatic test_ignored_writes;
		write_window(LEN_BITS'(3));
		send_sample(16'sd300);
		write_window(LEN_BITS'(0));
		send_sample(-16'sd301);
		write_window(LEN_BITS'(WIN_MAX + 1));
		write_window({LEN_BITS{1'b1}});
		send_sample(16'sd7);
	endtask

	// The largest window full of like extremes gives the largest sums.
	task automatic test_largest_window;
		write_window(LEN_BITS'(WIN_MAX));
		send_sample(16'sd32767);
		send_sample(16'sd32767);
		send_sample(-16'sd32768);
		write_window(LEN_BITS'(WIN_MAX));
		send_sample(-16'sd32768);
		send_sample(-16'sd32768);
	endtask

	// A window of two with sums of one and minus one, which must both round
	// toward zero.
	task automatic test_round_toward_zero;
		write_window(LEN_BITS'(2));
		send_sample(16'sd0);
		send_sample(-16'sd1);
		send_sample(16'sd2);
	endtask

	// Random bursts of samples over random windows. Now and then the window
	// write is skipped or is one the block must ignore, and now and then the
	// sender waits mid-burst until every average has come.
	task automatic test_random_traffic(input int unsigned count);
		int unsigned stop_at;
		int unsigned burst;
		int unsigned pick;
		stop_at = samples_sent + count;
		while (samples_sent < stop_at) begin
			pick = $urandom_range(11);
			if (pick == 0)
				write_window(LEN_BITS'($urandom_range(1) ? 0 :
					$urandom_range(WIN_MAX + 1, (1 << LEN_BITS) - 1)));
			else if (pick == 1)
				write_window(LEN_BITS'($urandom_range(1) ? 1 : WIN_MAX));
			else if (pick < 9)
				write_window(LEN_BITS'($urandom_range(1, WIN_MAX)));
			burst = $urandom_range(1, 40);
			for (int i = 0; i < burst; i++) begin
				send_sample(random_sample());
				if ($urandom_range(29) == 0)
					drain_results();
			end
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		window_len = WINDOW_RESET > WIN_MAX ? WIN_MAX : WINDOW_RESET;
		window_sum = 0;
		slot_ptr   = 0;
		is_primed  = 1'b0;

		test_reset_window();
		test_window_of_one();
		test_ignored_writes();
		test_largest_window();
		test_round_toward_zero();

		test_random_traffic(320);
		sender_idle_pct   = 85;
		receiver_idle_pct = 11;
		test_random_traffic(320);
		sender_idle_pct   = 0;
		receiver_idle_pct = 0;
		test_random_traffic(320);

		drain_results();
		repeat (40) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	// Far beyond the slowest correct run, so only a hang can end here.
	initial begin
		#20000000;
		$display("Mismatches found");
		$finish;
	end

endmodule

### sim.f
+incdir+sv
sv/pma_pkg.sv
sv/pma_front.sv
sv/pma_queue.sv
sv/pma_back.sv
sv/primed_moving_average.sv
test/primed_moving_average_tb.sv
